### rtl/cslex_pkg.sv
package cslex_pkg;

  // Defaults for the top-level parameters
  localparam int POSITION_BITS_DEF = 16;
  localparam int LENGTH_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF   = 4;

  // Fixed field widths
  localparam int CHAR_W = 8;
  localparam int KIND_W = 4;
  localparam int SYM_W  = 4;
  localparam int NUM_W  = 31;

  localparam logic [NUM_W-1:0] NUM_MAX = '1;

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_SYMBOL = 4'd0;
  localparam logic [KIND_W-1:0] KIND_NUMBER = 4'd1;
  localparam logic [KIND_W-1:0] KIND_IDENT  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_RETURN = 4'd3;
  localparam logic [KIND_W-1:0] KIND_IF     = 4'd4;
  localparam logic [KIND_W-1:0] KIND_ELSE   = 4'd5;
  localparam logic [KIND_W-1:0] KIND_WHILE  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_FOR    = 4'd7;
  localparam logic [KIND_W-1:0] KIND_END    = 4'd8;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 4'd9;

  // Symbol codes
  localparam logic [SYM_W-1:0] SYM_EQ     = 4'd0;
  localparam logic [SYM_W-1:0] SYM_NE     = 4'd1;
  localparam logic [SYM_W-1:0] SYM_LE     = 4'd2;
  localparam logic [SYM_W-1:0] SYM_GE     = 4'd3;
  localparam logic [SYM_W-1:0] SYM_LT     = 4'd4;
  localparam logic [SYM_W-1:0] SYM_GT     = 4'd5;
  localparam logic [SYM_W-1:0] SYM_PLUS   = 4'd6;
  localparam logic [SYM_W-1:0] SYM_MINUS  = 4'd7;
  localparam logic [SYM_W-1:0] SYM_STAR   = 4'd8;
  localparam logic [SYM_W-1:0] SYM_SLASH  = 4'd9;
  localparam logic [SYM_W-1:0] SYM_LPAREN = 4'd10;
  localparam logic [SYM_W-1:0] SYM_RPAREN = 4'd11;
  localparam logic [SYM_W-1:0] SYM_SEMI   = 4'd12;
  localparam logic [SYM_W-1:0] SYM_ASSIGN = 4'd13;
  localparam logic [SYM_W-1:0] SYM_LBRACE = 4'd14;
  localparam logic [SYM_W-1:0] SYM_RBRACE = 4'd15;

  // Queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

### rtl/cslex_front.sv
module cslex_front import cslex_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
  localparam int TOK_W = KIND_W + SYM_W + NUM_W + POSITION_BITS + LENGTH_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              end_of_text,
  output logic              push,
  output logic [TOK_W-1:0]  push_tok0,
  output logic [TOK_W-1:0]  push_tok1,
  output logic              push_two
);

  typedef enum logic [1:0] {MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_OPER} mode_t;
  typedef enum logic [1:0] {OP_LT, OP_GT, OP_ASSIGN, OP_BANG} oper_t;

  localparam int KW_COUNT = 5;
  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{"r", "e", "t", "u", "r", "n", 8'd0, 8'd0},
    '{"i", "f", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"e", "l", "s", "e", 8'd0, 8'd0, 8'd0, 8'd0},
    '{"w", "h", "i", "l", "e", 8'd0, 8'd0, 8'd0},
    '{"f", "o", "r", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd6, 3'd2, 3'd4, 3'd5, 3'd3};

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);
  localparam logic [LENGTH_BITS-1:0] LEN_TWO = LENGTH_BITS'(2);
  localparam logic [NUM_W-1:0]       NUM_ZERO = '0;
  localparam logic [SYM_W-1:0]       SYM_NONE = '0;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  mode_t                    mode_r, mode_nxt;
  oper_t                    oper_r, oper_nxt;
  logic [NUM_W-1:0]         acc_r, acc_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;
  logic [LENGTH_BITS-1:0]   len_r, len_nxt;
  logic [KW_COUNT-1:0]      cand_r, cand_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;

  logic                     accept;
  logic [7:0]               c;
  logic                     fl_valid, st_valid, cont;
  logic [TOK_W-1:0]         fl_tok, st_tok, pair_tok, end_tok;
  logic                     a_valid, b_valid;
  logic [TOK_W-1:0]         a_tok, b_tok;
  logic [KIND_W-1:0]        id_kind;
  logic [SYM_W-1:0]         pair_sym;
  logic [NUM_W+3:0]         acc_mul;
  logic [LENGTH_BITS-1:0]   len_grow;

  assign accept = in_valid & in_ready;
  assign c      = char_code;

  always_comb begin
    // keyword check at flush time: lengths are distinct, so at most one hits
    id_kind = KIND_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (cand_r[k] && len_r == LENGTH_BITS'(KW_LEN[k])) begin
        id_kind = KIND_RETURN + KIND_W'(k);
      end
    end

    fl_valid = (mode_r != MODE_IDLE);
    unique case (mode_r)
      MODE_IDENT:  fl_tok = {len_r, start_r, NUM_ZERO, SYM_NONE, id_kind};
      MODE_NUMBER: fl_tok = {len_r, start_r, acc_r, SYM_NONE, KIND_NUMBER};
      MODE_OPER: begin
        unique case (oper_r)
          OP_LT:     fl_tok = {LEN_ONE, start_r, NUM_ZERO, SYM_LT, KIND_SYMBOL};
          OP_GT:     fl_tok = {LEN_ONE, start_r, NUM_ZERO, SYM_GT, KIND_SYMBOL};
          OP_ASSIGN: fl_tok = {LEN_ONE, start_r, NUM_ZERO, SYM_ASSIGN, KIND_SYMBOL};
          default:   fl_tok = {LEN_ONE, start_r, NUM_ZERO, SYM_NONE, KIND_ERROR};
        endcase
      end
      default:     fl_tok = '0;
    endcase

    unique case (oper_r)
      OP_LT:     pair_sym = SYM_LE;
      OP_GT:     pair_sym = SYM_GE;
      OP_ASSIGN: pair_sym = SYM_EQ;
      default:   pair_sym = SYM_NE;
    endcase
    pair_tok = {LEN_TWO, start_r, NUM_ZERO, pair_sym, KIND_SYMBOL};
    end_tok  = {{LENGTH_BITS{1'b0}}, pos_r, NUM_ZERO, SYM_NONE, KIND_END};

    // a non-space character that opens no multi-character token gives a token now
    st_valid = 1'b1;
    st_tok   = {LEN_ONE, pos_r, NUM_ZERO, SYM_NONE, KIND_ERROR};
    if (is_space(c) || is_letter(c) || is_digit(c) ||
        c == "<" || c == ">" || c == "=" || c == "!") begin
      st_valid = 1'b0;
    end else begin
      case (c)
        "+":     st_tok = {LEN_ONE, pos_r, NUM_ZERO, SYM_PLUS, KIND_SYMBOL};
        "-":     st_tok = {LEN_ONE, pos_r, NUM_ZERO, SYM_MINUS, KIND_SYMBOL};
        "*":     st_tok = {LEN_ONE, pos_r, NUM_ZERO, SYM_STAR, KIND_SYMBOL};
        "/":     st_tok = {LEN_ONE, pos_r, NUM_ZERO, SYM_SLASH, KIND_SYMBOL};
        "(":     st_tok = {LEN_ONE, pos_r, NUM_ZERO, SYM_LPAREN, KIND_SYMBOL};
        ")":     st_tok = {LEN_ONE, pos_r, NUM_ZERO, SYM_RPAREN, KIND_SYMBOL};
        ";":     st_tok = {LEN_ONE, pos_r, NUM_ZERO, SYM_SEMI, KIND_SYMBOL};
        "{":     st_tok = {LEN_ONE, pos_r, NUM_ZERO, SYM_LBRACE, KIND_SYMBOL};
        "}":     st_tok = {LEN_ONE, pos_r, NUM_ZERO, SYM_RBRACE, KIND_SYMBOL};
        default: st_tok = {LEN_ONE, pos_r, NUM_ZERO, SYM_NONE, KIND_ERROR};
      endcase
    end

    cont = (mode_r == MODE_IDENT && (is_letter(c) || is_digit(c) || c == "_")) ||
           (mode_r == MODE_NUMBER && is_digit(c)) ||
           (mode_r == MODE_OPER && c == "=");

    // acc * 10 + digit as shift-add, then saturate
    acc_mul = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + (NUM_W + 4)'(c[3:0]);
    len_grow = (len_r != LEN_MAX) ? len_r + LEN_ONE : len_r;

    // up to two tokens per character, in order a then b
    if (end_of_text) begin
      a_valid = fl_valid;
      a_tok   = fl_tok;
      b_valid = 1'b1;
      b_tok   = end_tok;
    end else if (cont) begin
      a_valid = (mode_r == MODE_OPER);
      a_tok   = pair_tok;
      b_valid = 1'b0;
      b_tok   = st_tok;
    end else begin
      a_valid = fl_valid;
      a_tok   = fl_tok;
      b_valid = st_valid;
      b_tok   = st_tok;
    end

    push      = accept & (a_valid | b_valid);
    push_tok0 = a_valid ? a_tok : b_tok;
    push_tok1 = b_tok;
    push_two  = a_valid & b_valid;

    mode_nxt  = mode_r;
    oper_nxt  = oper_r;
    acc_nxt   = acc_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    cand_nxt  = cand_r;
    pos_nxt   = pos_r + POSITION_BITS'(1);

    if (end_of_text) begin
      mode_nxt  = MODE_IDLE;
      oper_nxt  = OP_LT;
      acc_nxt   = '0;
      start_nxt = '0;
      len_nxt   = '0;
      cand_nxt  = '1;
      pos_nxt   = '0;
    end else if (cont) begin
      unique case (mode_r)
        MODE_IDENT: begin
          for (int k = 0; k < KW_COUNT; k++) begin
            cand_nxt[k] = cand_r[k] & (len_r < LENGTH_BITS'(KW_LEN[k])) &
                          (c == KW_TEXT[k][len_r[2:0]]);
          end
          len_nxt = len_grow;
        end
        MODE_NUMBER: begin
          acc_nxt = (acc_mul > {4'b0, NUM_MAX}) ? NUM_MAX : acc_mul[NUM_W-1:0];
          len_nxt = len_grow;
        end
        default: mode_nxt = MODE_IDLE;
      endcase
    end else begin
      if (fl_valid) begin
        mode_nxt = MODE_IDLE;
        cand_nxt = '1;
        acc_nxt  = '0;
      end
      if (!is_space(c)) begin
        start_nxt = pos_r;
        len_nxt   = LEN_ONE;
        if (c == "<" || c == ">" || c == "=" || c == "!") begin
          mode_nxt = MODE_OPER;
          oper_nxt = (c == "<") ? OP_LT : (c == ">") ? OP_GT :
                     (c == "=") ? OP_ASSIGN : OP_BANG;
        end else if (is_letter(c)) begin
          mode_nxt = MODE_IDENT;
          for (int k = 0; k < KW_COUNT; k++) begin
            cand_nxt[k] = (c == KW_TEXT[k][0]);
          end
        end else if (is_digit(c)) begin
          mode_nxt = MODE_NUMBER;
          acc_nxt  = NUM_W'(c[3:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      oper_r  <= OP_LT;
      acc_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
      cand_r  <= '1;
      pos_r   <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      oper_r  <= oper_nxt;
      acc_r   <= acc_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      cand_r  <= cand_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

### rtl/cslex_queue.sv
module cslex_queue import cslex_pkg::*; #(
  parameter int DW    = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] head_data,
  output q_stat_t       stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [DW-1:0] mem [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_nxt  = (wr_r == PTR_LAST) ? '0 : wr_r + PW'(1);
    rd_nxt  = (rd_r == PTR_LAST) ? '0 : rd_r + PW'(1);
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CNT_FULL);
  assign head_data  = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_nxt;
      if (pop)  rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/cslex_back.sv
module cslex_back import cslex_pkg::*; #(
  parameter int TOK_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  q_stat_t          q_stat,
  input  logic [TOK_W-1:0] head_tok0,
  input  logic [TOK_W-1:0] head_tok1,
  input  logic             head_two,
  output logic             pop,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [TOK_W-1:0] out_tok,
  output logic             out_last
);

  logic             valid_r, valid_nxt;
  logic             sub_r, sub_nxt;
  logic [TOK_W-1:0] tok_r, tok_nxt;
  logic             last_r, last_nxt;
  logic             load;

  // take the next token when the output register is free or being drained
  assign load = ~q_stat.empty & (~valid_r | out_ready);

  always_comb begin
    valid_nxt = valid_r & ~out_ready;
    sub_nxt   = sub_r;
    tok_nxt   = tok_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      if (head_two && !sub_r) begin
        tok_nxt  = head_tok0;
        last_nxt = 1'b0;
        sub_nxt  = 1'b1;
      end else begin
        tok_nxt  = sub_r ? head_tok1 : head_tok0;
        last_nxt = 1'b1;
        sub_nxt  = 1'b0;
        pop      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sub_r   <= sub_nxt;
    end
    tok_r  <= tok_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_tok   = tok_r;
  assign out_last  = last_r;

endmodule

### rtl/c_subset_lexer_unit.sv
// Path: a character's tokens go through the token queue into the output register.
// Throughput: one character request per cycle while the queue has room; one token
// per cycle on the output while out_tready is high, so two tokens leave in turn.
// The token queue (QUEUE_DEPTH entries) absorbs those bursts.
// Reset: rst_n synchronous, active low; clears lexer state, text offset,
// queue pointers and the output valid.
module c_subset_lexer_unit import cslex_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // character requests
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] char_code
  input  logic              in_tlast,   // end_of_text
  // token results
  output logic              out_tvalid,
  input  logic              out_tready,
  // from bit 0: symbol_code(4), number_value(31), ident_start(POSITION_BITS),
  // ident_length(LENGTH_BITS), zero fill to whole bytes
  output logic [((SYM_W + NUM_W + POSITION_BITS + LENGTH_BITS + 7) / 8) * 8 - 1:0]
                            out_tdata,
  output logic [3:0]        out_tuser,  // token_kind
  output logic              out_tlast   // last_of_run
);

  localparam int TOK_W  = KIND_W + SYM_W + NUM_W + POSITION_BITS + LENGTH_BITS;
  localparam int OUT_DW = ((SYM_W + NUM_W + POSITION_BITS + LENGTH_BITS + 7) / 8) * 8;
  // queue entry: {two, tok1, tok0}
  localparam int ENT_W  = 2 * TOK_W + 1;

  // Token layout inside the design, low bits first:
  // kind, symbol, number, start, length. The top bits map straight to tdata.

  q_stat_t          q_stat;
  logic             push, push_two, pop;
  logic [TOK_W-1:0] push_tok0, push_tok1;
  logic [ENT_W-1:0] head;
  logic [TOK_W-1:0] out_tok;

  // Front never stalls on its own: a character is taken whenever the queue has room.
  assign in_tready = ~q_stat.full;

  // Front: classifies each character, keeps the lexer state and
  // builds the zero, one or two tokens it causes in the same cycle.
  cslex_front #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .char_code   (in_tdata),
    .end_of_text (in_tlast),
    .push        (push),
    .push_tok0   (push_tok0),
    .push_tok1   (push_tok1),
    .push_two    (push_two)
  );

  // Short queue of per-character token groups decouples the two sides.
  cslex_queue #(
    .DW    (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_two, push_tok1, push_tok0}),
    .pop       (pop),
    .head_data (head),
    .stat      (q_stat)
  );

  // Back: splits a group into single tokens and holds the output register;
  // tlast goes on the last token of a group.
  cslex_back #(
    .TOK_W (TOK_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_tok0 (head[TOK_W-1:0]),
    .head_tok1 (head[2*TOK_W-1:TOK_W]),
    .head_two  (head[ENT_W-1]),
    .pop       (pop),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_tok   (out_tok),
    .out_last  (out_tlast)
  );

  assign out_tuser = out_tok[KIND_W-1:0];
  assign out_tdata = OUT_DW'(out_tok[TOK_W-1:KIND_W]);

endmodule

### rtl/cslex_checker.sv
module cslex_checker import cslex_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [((SYM_W + NUM_W + POSITION_BITS + LENGTH_BITS + 7) / 8) * 8 - 1:0]
                    out_tdata,
  input logic [3:0] out_tuser,
  input logic       out_tlast
);

  localparam int NUM_LO = SYM_W;
  localparam int LEN_LO = SYM_W + NUM_W + POSITION_BITS;
  localparam int LEN_HI = LEN_LO + LENGTH_BITS - 1;

  logic [LENGTH_BITS-1:0] len_f;
  logic [NUM_W-1:0]       num_f;

  assign len_f = out_tdata[LEN_HI:LEN_LO];
  assign num_f = out_tdata[NUM_LO + NUM_W - 1:NUM_LO];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= KIND_ERROR)
    else $error("token kind out of range");

  // end token closes its run and has no length
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_END |-> out_tlast && len_f == '0)
    else $error("end token malformed");

  a_symbol_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_SYMBOL |->
      (len_f == LENGTH_BITS'(1) || len_f == LENGTH_BITS'(2)) && num_f == '0)
    else $error("symbol token malformed");

endmodule

bind c_subset_lexer_unit cslex_checker #(
  .POSITION_BITS (POSITION_BITS),
  .LENGTH_BITS   (LENGTH_BITS)
) u_cslex_checker (.*);
